// ===== design/wts_pkg.sv =====
// Shared constants, types and helpers for the weighted table sampler.
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int WEIGHT_BITS   = 16;

  // Field widths of the channels.
  localparam int INDEX_W  = 4;
  localparam int SYM_W    = 8;
  localparam int WIN_W    = 16;
  localparam int FRAC_W   = 32;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CUM_W  = WEIGHT_BITS + $clog2(TABLE_ENTRIES);
  localparam int PROD_W = CUM_W + FRAC_W;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [SYM_W-1:0] START_SYMBOL_RESET = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOTAL,
    S_MUL,
    S_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic below_last;
    logic at_last;
  } cell_ctl_t;

  typedef struct packed {
    logic             taken;
    logic [SYM_W-1:0] symbol;
  } chain_t;

  // Keep the low WEIGHT_BITS of the incoming weight, widened to the sum width.
  function automatic logic [CUM_W-1:0] mask_weight(input logic [WIN_W-1:0] w);
    logic [CUM_W-1:0] r;
    r = '0;
    for (int b = 0; b < CUM_W; b++) begin
      if (b < WEIGHT_BITS && b < WIN_W) begin
        r[b] = w[b];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/wts_ifs.sv =====
// Handshake channel interfaces: command items, result items, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface wts_cmd_if
  import wts_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] entry_index;
  logic [SYM_W-1:0]   entry_symbol;
  logic [WIN_W-1:0]   entry_weight;
  logic               entry_last;
  logic [FRAC_W-1:0]  random_fraction;

  modport source (output valid, kind, entry_index, entry_symbol, entry_weight,
                  entry_last, random_fraction, input ready);
  modport sink (input valid, kind, entry_index, entry_symbol, entry_weight,
                entry_last, random_fraction, output ready);
endinterface

interface wts_rsp_if
  import wts_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] drawn_symbol;
  logic             fell_back;

  modport source (output valid, drawn_symbol, fell_back, input ready);
  modport sink (input valid, drawn_symbol, fell_back, output ready);
endinterface

interface wts_cfg_if
  import wts_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/wts_cell.sv =====
// One table cell: holds an entry, builds its running sum from its left neighbor,
// compares against the scaled draw and passes the first hit down the chain.
`timescale 1ns / 1ps
`default_nettype none

module wts_cell
  import wts_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CUM_W-1:0]  weight,
  input  logic [SYM_W-1:0]  symbol_load,
  input  logic [CUM_W-1:0]  prev_cum,
  input  logic [PROD_W-1:0] product,
  input  chain_t            chain_in,
  output logic [CUM_W-1:0]  cum,
  output chain_t            chain_out
);

  logic [SYM_W-1:0] symbol;
  logic             hit;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cum    <= prev_cum + weight;
      symbol <= symbol_load;
    end
    if (ctl.cmp) begin
      // cum * 2^32 >= fraction * total, exact
      hit <= (({cum, {FRAC_W{1'b0}}} >= product) && ctl.below_last) || ctl.at_last;
    end
  end

  always_comb begin
    chain_out.taken  = chain_in.taken | hit;
    chain_out.symbol = chain_in.taken ? chain_in.symbol : symbol;
  end

endmodule

`default_nettype wire

// ===== design/weighted_table_sampler.sv =====
// Top level: command decode, draw sequencer, multiplier, cell row, result register.
`timescale 1ns / 1ps
`default_nettype none

// Weighted table sampler. Load items write one table entry each and are taken
// while the sampler is idle; the entry's running sum is formed from the cell
// to its left. A draw item passes these steps from acceptance to the result
// register: accept, read of the table total from the last valid cell, one
// 32 x 20 bit multiply, a parallel compare in every cell, and the pick of the
// first hit through the cell chain. An empty table or a zero total skips the
// compare. The sampler works on one item at a time and takes the next item in
// the cycle after a draw's result is loaded; a waiting result stays in the
// output register while loads continue. If that register is still occupied
// when a draw finishes, the draw holds in its last step until it frees. An
// empty table or a zero total returns the incremented current symbol with
// fell_back set. Writing the configuration register loads the current symbol
// with the written data.
module weighted_table_sampler
  import wts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  wts_cmd_if.sink   cmd,
  wts_rsp_if.source rsp,
  wts_cfg_if.sink   cfg
);

  state_t state, state_next;

  logic [CNT_W-1:0]  entry_count;
  logic [SYM_W-1:0]  current_symbol;
  logic [FRAC_W-1:0] frac;
  logic [CUM_W-1:0]  total;
  logic              empty;
  logic              fallback;
  logic [PROD_W-1:0] product;
  logic              rsp_valid;
  logic [SYM_W-1:0]  rsp_symbol;
  logic              rsp_fell_back;

  logic              cmd_ready;
  logic              cmd_fire;
  logic              load_fire;
  logic              emit_fire;
  logic [CUM_W-1:0]  weight_ext;
  logic [IDX_W-1:0]  last_idx;
  logic [SYM_W-1:0]  next_symbol;

  logic [CUM_W-1:0]  cum_row [TABLE_ENTRIES];
  chain_t            chain   [TABLE_ENTRIES+1];

  assign cmd_fire   = cmd.valid && cmd_ready;
  assign load_fire  = cmd_fire && (cmd.kind == KIND_LOAD);
  assign emit_fire  = (state == S_EMIT) && (!rsp_valid || rsp.ready);
  assign weight_ext = mask_weight(cmd.entry_weight);
  assign last_idx   = IDX_W'(entry_count - CNT_W'(1));
  assign next_symbol = current_symbol + SYM_W'(1);

  assign cmd.ready        = cmd_ready;
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = rsp_valid;
  assign rsp.drawn_symbol = rsp_symbol;
  assign rsp.fell_back    = rsp_fell_back;

  assign chain[0] = '{taken: 1'b0, symbol: '0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [CUM_W-1:0] prev_cum;

    assign ctl.load       = load_fire && (cmd.entry_index == INDEX_W'(i));
    assign ctl.cmp        = (state == S_CMP);
    assign ctl.below_last = (CNT_W'(i + 1) < entry_count);
    assign ctl.at_last    = (CNT_W'(i + 1) == entry_count);

    if (i == 0) begin : g_first
      assign prev_cum = '0;
    end else begin : g_rest
      assign prev_cum = cum_row[i-1];
    end

    wts_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .weight      (weight_ext),
      .symbol_load (cmd.entry_symbol),
      .prev_cum    (prev_cum),
      .product     (product),
      .chain_in    (chain[i]),
      .cum         (cum_row[i]),
      .chain_out   (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd.valid && cmd.kind == KIND_DRAW) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: state_next = S_MUL;
      S_MUL: begin
        if (empty || total == '0) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: state_next = S_EMIT;
      S_EMIT: begin
        if (emit_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      current_symbol <= START_SYMBOL_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      if (load_fire && cmd.entry_last &&
          (CNT_W'(cmd.entry_index) < CNT_W'(TABLE_ENTRIES))) begin
        entry_count <= CNT_W'(cmd.entry_index) + CNT_W'(1);
      end
      if (cfg.valid) begin
        current_symbol <= cfg.data;
      end else if (emit_fire && fallback) begin
        current_symbol <= next_symbol;
      end
      if (emit_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Draw datapath.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      frac <= cmd.random_fraction;
    end
    if (state == S_TOTAL) begin
      total <= cum_row[last_idx];
      empty <= (entry_count == '0);
    end
    if (state == S_MUL) begin
      fallback <= empty || (total == '0);
      product  <= PROD_W'(frac) * PROD_W'(total);
    end
    if (emit_fire) begin
      rsp_symbol    <= fallback ? next_symbol : chain[TABLE_ENTRIES].symbol;
      rsp_fell_back <= fallback;
    end
  end

endmodule

`default_nettype wire

// ===== design/wts_checker.sv =====
// Port-level checks for the weighted table sampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wts_checker
  import wts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             cmd_kind,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [SYM_W-1:0] rsp_drawn_symbol,
  input logic             rsp_fell_back
);

  // A result never withdraws while stalled.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped while stalled");

  // Stalled result payload holds.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_drawn_symbol) && $stable(rsp_fell_back))
    else $error("result item changed while stalled");

  // A draw occupies the sampler: no item is taken in the following cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_kind == KIND_DRAW |=> !cmd_ready)
    else $error("item accepted right after a draw");

  // A load makes no result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && cmd_valid && cmd_ready && cmd_kind == KIND_LOAD |=> !rsp_valid)
    else $error("result item after a load");

endmodule

bind weighted_table_sampler wts_checker u_wts_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_kind         (cmd.kind),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_drawn_symbol (rsp.drawn_symbol),
  .rsp_fell_back    (rsp.fell_back)
);

`default_nettype wire
